FILE: src/scs_pkg.sv
// ============================================================================
// scs_pkg
// Shared types, character codes and the block-comment step function for the
// source comment stripper.
// ============================================================================
package scs_pkg;

    // Character codes
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Result slots per request in the back end
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);

    // Line-comment stage states; code 3 behaves as normal
    typedef enum logic [1:0] {
        LS_NORMAL = 2'd0,
        LS_SLASH  = 2'd1,
        LS_INLINE = 2'd2
    } line_state_t;

    // Block-comment stage states
    typedef enum logic [1:0] {
        BS_NORMAL = 2'd0,
        BS_SLASH  = 2'd1,
        BS_BLOCK  = 2'd2,
        BS_STAR   = 2'd3
    } block_state_t;

    // Bytes that survive the line stage for one source byte
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] cnt;
        logic       last;
    } line_item_t;

    // One byte through the block stage: next state and up to two bytes out
    typedef struct packed {
        block_state_t state;
        logic [1:0]   n;
        logic [7:0]   o0;
        logic [7:0]   o1;
    } block_step_t;

    function automatic block_step_t block_step(input block_state_t st,
                                               input logic [7:0] c);
        block_step_t r;
        r.state = st;
        r.n     = 2'd0;
        r.o0    = c;
        r.o1    = c;
        case (st)
            BS_NORMAL:
            begin
                if (c == CH_SLASH) r.state = BS_SLASH;
                else               r.n     = 2'd1;
            end
            BS_SLASH:
            begin
                if (c == CH_STAR) begin
                    r.state = BS_BLOCK;
                end else if (c == CH_SLASH) begin
                    r.n  = 2'd1;
                    r.o0 = CH_SLASH;
                end else begin
                    r.n     = 2'd2;
                    r.o0    = CH_SLASH;
                    r.state = BS_NORMAL;
                end
            end
            BS_BLOCK:
            begin
                if (c == CH_NEWLINE)   r.n     = 2'd1;
                else if (c == CH_STAR) r.state = BS_STAR;
            end
            default:
            begin
                // after '*' inside a comment
                if (c == CH_SLASH) begin
                    r.state = BS_NORMAL;
                end else if (c == CH_NEWLINE) begin
                    r.n     = 2'd1;
                    r.state = BS_BLOCK;
                end else if (c != CH_STAR) begin
                    r.state = BS_BLOCK;
                end
            end
        endcase
        return r;
    endfunction

endpackage

FILE: src/scs_line_front.sv
// ============================================================================
// scs_line_front
// Front end: takes one source byte per cycle unless the queue is full, removes
// line comments and forwards the surviving bytes (zero to two) as one queue request.
// ============================================================================
module scs_line_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    output logic              push,
    output scs_pkg::line_item_t push_item,
    input  logic              q_full
);
    import scs_pkg::*;

    line_state_t state_reg;
    line_state_t state_next;
    line_item_t  item;
    logic        accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Line stage next state and forwarded bytes
    always_comb
    begin
        state_next = state_reg;
        item.b0    = in_char;
        item.b1    = in_char;
        item.cnt   = 2'd0;
        item.last  = in_last;
        case (state_reg)
            LS_SLASH:
            begin
                if (in_char == CH_SLASH) begin
                    state_next = LS_INLINE;
                end else begin
                    item.b0    = CH_SLASH;
                    item.cnt   = 2'd2;
                    state_next = LS_NORMAL;
                end
            end
            LS_INLINE:
            begin
                if (in_char == CH_NEWLINE) begin
                    item.cnt   = 2'd1;
                    state_next = LS_NORMAL;
                end
            end
            default:
            begin
                if (in_char == CH_SLASH) begin
                    state_next = LS_SLASH;
                end else begin
                    item.cnt   = 2'd1;
                    state_next = LS_NORMAL;
                end
            end
        endcase
        // End of text: flush a held slash, restart the stage
        if (in_last) begin
            if (state_next == LS_SLASH) begin
                item.b0  = CH_SLASH;
                item.cnt = 2'd1;
            end
            state_next = LS_NORMAL;
        end
    end

    assign push      = accept && ((item.cnt != 2'd0) || in_last);
    assign push_item = item;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      state_reg <= LS_NORMAL;
        else if (accept) state_reg <= state_next;
    end

endmodule

FILE: src/scs_queue.sv
// ============================================================================
// scs_queue
// Short register queue between the line front end and the block back end.
// ============================================================================
module scs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scs_pkg::line_item_t push_item,
    output logic                full,
    output logic                q_valid,
    output scs_pkg::line_item_t q_item,
    input  logic                pop
);
    import scs_pkg::*;

    line_item_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW:0]      count_reg;
    logic [QUEUE_AW:0]      count_next;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: src/scs_block_back.sv
// ============================================================================
// scs_block_back
// Back end: runs the block-comment stage over one queued request, builds its
// results (up to four) in an output buffer, handed out one per cycle unless stalled.
// ============================================================================
module scs_block_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  scs_pkg::line_item_t q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_char,
    output logic                has_char,
    output logic                out_last,
    output logic                unterminated
);
    import scs_pkg::*;

    block_state_t        bs_reg;
    block_state_t        bs_next;
    logic [7:0]          char_reg  [SLOT_COUNT];
    logic                has_reg   [SLOT_COUNT];
    logic [7:0]          char_next [SLOT_COUNT];
    logic                has_next  [SLOT_COUNT];
    logic [SLOT_AW:0]    cnt_reg;
    logic [SLOT_AW:0]    cnt_next;
    logic [SLOT_AW-1:0]  ptr_reg;
    logic                last_reg;
    logic                open_reg;
    logic                open_next;
    logic                out_accept;

    // Build the result list for the request at the head of the queue
    always_comb
    begin
        block_step_t st;
        st        = '0;
        bs_next   = bs_reg;
        cnt_next  = '0;
        open_next = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            char_next[i] = 8'd0;
            has_next[i]  = 1'b1;
        end
        for (int k = 0; k < 2; k++) begin
            if (k < int'(q_item.cnt)) begin
                st      = block_step(bs_next, (k == 0) ? q_item.b0 : q_item.b1);
                bs_next = st.state;
                if (st.n != 2'd0 && cnt_next < (SLOT_AW+1)'(SLOT_COUNT)) begin
                    char_next[cnt_next[SLOT_AW-1:0]] = st.o0;
                    cnt_next = cnt_next + 1'b1;
                end
                if (st.n == 2'd2 && cnt_next < (SLOT_AW+1)'(SLOT_COUNT)) begin
                    char_next[cnt_next[SLOT_AW-1:0]] = st.o1;
                    cnt_next = cnt_next + 1'b1;
                end
            end
        end
        // End of text: flush a held slash, report an open comment
        if (q_item.last) begin
            if (bs_next == BS_SLASH && cnt_next < (SLOT_AW+1)'(SLOT_COUNT)) begin
                char_next[cnt_next[SLOT_AW-1:0]] = CH_SLASH;
                cnt_next = cnt_next + 1'b1;
            end
            open_next = bs_next inside {BS_BLOCK, BS_STAR};
            if (cnt_next == '0) begin
                has_next[0] = 1'b0;
                cnt_next    = (SLOT_AW+1)'(1);
            end
            bs_next = BS_NORMAL;
        end
    end

    // Output side
    assign out_valid    = (cnt_reg != '0);
    assign out_accept   = out_valid && !out_stall;
    assign out_char     = char_reg[ptr_reg];
    assign has_char     = has_reg[ptr_reg];
    assign out_last     = last_reg && (cnt_reg == (SLOT_AW+1)'(1));
    assign unterminated = open_reg && out_last;

    // Load the next request once the buffer drains this cycle
    assign pop = q_valid &&
                 ((cnt_reg == '0) || ((cnt_reg == (SLOT_AW+1)'(1)) && out_accept));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bs_reg   <= BS_NORMAL;
            cnt_reg  <= '0;
            ptr_reg  <= '0;
            last_reg <= 1'b0;
            open_reg <= 1'b0;
        end else if (pop) begin
            bs_reg   <= bs_next;
            cnt_reg  <= cnt_next;
            ptr_reg  <= '0;
            last_reg <= q_item.last;
            open_reg <= open_next;
        end else if (out_accept) begin
            cnt_reg <= cnt_reg - 1'b1;
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                char_reg[i] <= char_next[i];
                has_reg[i]  <= has_next[i];
            end
        end
    end

endmodule

FILE: src/source_comment_stripper.sv
// ============================================================================
// source_comment_stripper
// Streams source text and removes line and block comments in two stages.
// ============================================================================
// A byte's results pass through the queue and then the back end's output buffer.
// Throughput: one byte per cycle in, one result per cycle out while out_stall is
// low, so a byte yielding several results holds the back end until all are out,
// and the two-entry queue absorbs that before the input stalls.
// Reset: asynchronous, active low; both stages return to normal, queue and
// output buffer empty.
module source_comment_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       out_last,
    output logic       unterminated
);
    import scs_pkg::*;

    logic       push;
    line_item_t push_item;
    logic       q_full;
    logic       q_valid;
    line_item_t q_item;
    logic       pop;

    // Line-comment front end
    scs_line_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .in_last   (in_last),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // Decoupling queue
    scs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // Block-comment back end
    scs_block_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .has_char     (has_char),
        .out_last     (out_last),
        .unterminated (unterminated)
    );

endmodule
